>>> design/dtrhs_pkg.sv
// ----------------------------------------------------------------------------
// dtrhs_pkg
// Shared constants, codes and control structs of the draw task scheduler.
// ----------------------------------------------------------------------------
package dtrhs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WORKERS_DEF     = 4;
    localparam int GRID_COLS_DEF   = 16;
    localparam int GRID_ROWS_DEF   = 16;

    localparam int CMD_W    = 2;
    localparam int WID_W    = 3;
    localparam int TAG_W    = 16;
    localparam int SURF_W   = 4;
    localparam int COORD_W  = 12;
    localparam int SIZE_W   = 13;
    localparam int STATUS_W = 2;
    localparam int QCNT_W   = 5;
    localparam int BUSY_W   = 8;

    localparam logic [CMD_W-1:0] CMD_ENQ      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic                load;
        logic                div_start;
        logic                enq_write;
        logic                scan_init;
        logic                q_next;
        logic                k_next;
        logic                grant;
        logic                sh_write;
        logic                sh_done;
        logic                finish_worker;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             wid_bad;
        logic             div_done;
        logic             div_last;
        logic             q_end;
        logic             q_ok;
        logic             k_end;
        logic             k_clash;
        logic             sh_end;
    } t_dp_stat;

endpackage

>>> design/dtrhs_div.sv
// ----------------------------------------------------------------------------
// dtrhs_div
// Restoring divider, one quotient bit per cycle; a zero divisor counts as one.
// ----------------------------------------------------------------------------
module dtrhs_div
    import dtrhs_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_shift;
    logic             w_ge;

    assign w_shift = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= (i_den == '0) ? DEN_W'(1) : i_den;
        end else if (r_run) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> design/dtrhs_dp.sv
// ----------------------------------------------------------------------------
// dtrhs_dp
// Datapath: task queue memory, worker records, grid mapping and hazard checks.
// ----------------------------------------------------------------------------
module dtrhs_dp
    import dtrhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int WORKERS     = WORKERS_DEF,
    parameter int GRID_COLS   = GRID_COLS_DEF,
    parameter int GRID_ROWS   = GRID_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CMD_W-1:0]    i_in_cmd,
    input  logic [WID_W-1:0]    i_in_wid,
    input  logic [TAG_W-1:0]    i_in_tag,
    input  logic [SURF_W-1:0]   i_in_surf,
    input  logic                i_in_hw,
    input  logic [COORD_W-1:0]  i_in_x1,
    input  logic [COORD_W-1:0]  i_in_y1,
    input  logic [COORD_W-1:0]  i_in_x2,
    input  logic [COORD_W-1:0]  i_in_y2,
    input  logic [SIZE_W-1:0]   i_in_w,
    input  logic [SIZE_W-1:0]   i_in_h,
    output logic                o_granted,
    output logic [TAG_W-1:0]    o_granted_tag,
    output logic [STATUS_W-1:0] o_status,
    output logic [QCNT_W-1:0]   o_queue_count,
    output logic [BUSY_W-1:0]   o_busy_mask
);

    localparam int QW       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int WW       = $clog2(WORKERS);
    localparam int CW       = $clog2(GRID_COLS);
    localparam int RW       = $clog2(GRID_ROWS);
    localparam int CELL_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int CELL_W   = $clog2(CELL_MAX + 1);
    localparam int NUM_W    = SIZE_W + CELL_W;
    localparam int RECT_W   = 1 + 2 * CW + 2 * RW;
    localparam int EW       = TAG_W + SURF_W + 1 + RECT_W;
    localparam logic [WID_W:0] WORKERS_L = (WID_W + 1)'(WORKERS);

    // rectangle layout: {empty, x1, x2, y1, y2}
    function automatic logic rect_meet(input logic [RECT_W-1:0] a,
                                       input logic [RECT_W-1:0] b);
        logic [CW-1:0] ax1, ax2, bx1, bx2;
        logic [RW-1:0] ay1, ay2, by1, by2;
        ax1 = a[2*RW+2*CW-1:2*RW+CW];
        ax2 = a[2*RW+CW-1:2*RW];
        ay1 = a[2*RW-1:RW];
        ay2 = a[RW-1:0];
        bx1 = b[2*RW+2*CW-1:2*RW+CW];
        bx2 = b[2*RW+CW-1:2*RW];
        by1 = b[2*RW-1:RW];
        by2 = b[RW-1:0];
        return !a[RECT_W-1] && !b[RECT_W-1] && (ax1 <= bx2) && (bx1 <= ax2)
               && (ay1 <= by2) && (by1 <= ay2);
    endfunction

    logic [CMD_W-1:0]   r_cmd;
    logic [WID_W-1:0]   r_wid;
    logic [TAG_W-1:0]   r_tag;
    logic [SURF_W-1:0]  r_surf;
    logic               r_hw;
    logic [COORD_W-1:0] r_x1, r_y1;
    logic [SIZE_W-1:0]  r_x2p, r_y2p;
    logic [SIZE_W-1:0]  r_w, r_h;

    logic [CNT_W-1:0]   r_len, r_q, r_k;
    logic [WORKERS-1:0] r_busy;
    logic [SURF_W-1:0]  r_wsurf [WORKERS];
    logic [RECT_W-1:0]  r_wrect [WORKERS];

    logic [EW-1:0]      mem [QUEUE_DEPTH];
    logic [EW-1:0]      r_ea, r_eb;

    logic [1:0]         r_div_sel;
    logic [CW-1:0]      r_gx1, r_gx2;
    logic [RW-1:0]      r_gy1, r_gy2;

    logic                r_res_granted;
    logic [TAG_W-1:0]    r_res_tag;
    logic [STATUS_W-1:0] r_res_status;

    logic                r_o_granted;
    logic [TAG_W-1:0]    r_o_tag;
    logic [STATUS_W-1:0] r_o_status;
    logic [QCNT_W-1:0]   r_o_count;
    logic [BUSY_W-1:0]   r_o_busy;

    logic [SIZE_W-1:0]  w_coord, w_size;
    logic [CELL_W-1:0]  w_cells;
    logic [NUM_W-1:0]   w_num, w_quot, w_lim;
    logic               w_div_done;
    logic [RECT_W-1:0]  w_new_rect, w_a_rect, w_b_rect;
    logic               w_new_empty;
    logic               w_wclash;
    logic [WW-1:0]      w_widx;
    logic [QW-1:0]      w_waddr;
    logic [EW-1:0]      w_wdata;

    // operand select for the four grid corners
    always_comb begin
        case (r_div_sel)
            2'd0: begin
                w_coord = SIZE_W'(r_x1);
                w_size  = r_w;
                w_cells = CELL_W'(GRID_COLS);
            end
            2'd1: begin
                w_coord = r_x2p;
                w_size  = r_w;
                w_cells = CELL_W'(GRID_COLS);
            end
            2'd2: begin
                w_coord = SIZE_W'(r_y1);
                w_size  = r_h;
                w_cells = CELL_W'(GRID_ROWS);
            end
            default: begin
                w_coord = r_y2p;
                w_size  = r_h;
                w_cells = CELL_W'(GRID_ROWS);
            end
        endcase
    end

    assign w_num = NUM_W'(w_coord) * NUM_W'(w_cells);
    assign w_lim = NUM_W'(w_cells) - NUM_W'(1);

    dtrhs_div #(
        .NUM_W (NUM_W),
        .DEN_W (SIZE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_size),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    logic [NUM_W-1:0] w_clamped;
    assign w_clamped = (w_quot > w_lim) ? w_lim : w_quot;

    assign w_new_empty = (r_gx1 > r_gx2) || (r_gy1 > r_gy2);
    assign w_new_rect  = {w_new_empty, r_gx1, r_gx2, r_gy1, r_gy2};
    assign w_a_rect    = r_ea[RECT_W-1:0];
    assign w_b_rect    = r_eb[RECT_W-1:0];
    assign w_widx      = r_wid[WW-1:0];

    always_comb begin
        w_wclash = 1'b0;
        for (int i = 0; i < WORKERS; i++) begin
            if (r_busy[i] && ((r_wsurf[i] != r_ea[RECT_W+SURF_W:RECT_W+1])
                              || rect_meet(r_wrect[i], w_a_rect))) begin
                w_wclash = 1'b1;
            end
        end
    end

    // enqueue writes at the tail, compaction moves an entry down by one
    assign w_waddr = i_cmd.enq_write ? r_len[QW-1:0] : QW'(r_k - 1'b1);
    assign w_wdata = i_cmd.enq_write ? {r_tag, r_surf, r_hw, w_new_rect} : r_eb;

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_write || i_cmd.sh_write) begin
            mem[w_waddr] <= w_wdata;
        end
        r_ea <= mem[r_q[QW-1:0]];
        r_eb <= mem[r_k[QW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_busy <= '0;
            r_q    <= '0;
            r_k    <= '0;
        end else begin
            if (i_cmd.enq_write) begin
                r_len <= r_len + 1'b1;
            end
            if (i_cmd.sh_done) begin
                r_len <= r_len - 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_q <= '0;
                r_k <= '0;
            end
            if (i_cmd.q_next) begin
                r_q <= r_q + 1'b1;
                r_k <= '0;
            end
            if (i_cmd.k_next || i_cmd.sh_write) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.grant) begin
                r_k            <= r_q + 1'b1;
                r_busy[w_widx] <= 1'b1;
            end
            if (i_cmd.finish_worker && ({1'b0, r_wid} < WORKERS_L)) begin
                r_busy[w_widx] <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd         <= i_in_cmd;
            r_wid         <= i_in_wid;
            r_tag         <= i_in_tag;
            r_surf        <= i_in_surf;
            r_hw          <= i_in_hw;
            r_x1          <= i_in_x1;
            r_y1          <= i_in_y1;
            r_x2p         <= SIZE_W'(i_in_x2) + SIZE_W'(1);
            r_y2p         <= SIZE_W'(i_in_y2) + SIZE_W'(1);
            r_w           <= i_in_w;
            r_h           <= i_in_h;
            r_div_sel     <= '0;
            r_res_granted <= 1'b0;
            r_res_tag     <= '0;
            r_res_status  <= ST_OK;
        end
        if (w_div_done) begin
            r_div_sel <= r_div_sel + 1'b1;
            case (r_div_sel)
                2'd0:    r_gx1 <= CW'(w_clamped);
                2'd1:    r_gx2 <= CW'(w_clamped);
                2'd2:    r_gy1 <= RW'(w_clamped);
                default: r_gy2 <= RW'(w_clamped);
            endcase
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.grant) begin
            r_res_granted    <= 1'b1;
            r_res_tag        <= r_ea[EW-1:EW-TAG_W];
            r_wsurf[w_widx]  <= r_ea[RECT_W+SURF_W:RECT_W+1];
            r_wrect[w_widx]  <= w_a_rect;
        end
        if (i_cmd.out_load) begin
            r_o_granted <= r_res_granted;
            r_o_tag     <= r_res_tag;
            r_o_status  <= r_res_status;
            r_o_count   <= QCNT_W'(r_len);
            r_o_busy    <= BUSY_W'(r_busy);
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.cmd      = r_cmd;
        o_stat.full     = r_len >= CNT_W'(QUEUE_DEPTH);
        o_stat.wid_bad  = ({1'b0, r_wid} >= WORKERS_L) || r_busy[w_widx];
        o_stat.div_done = w_div_done;
        o_stat.div_last = r_div_sel == 2'd3;
        o_stat.q_end    = r_q >= r_len;
        // worker 0 takes software tasks, the rest hardware tasks
        o_stat.q_ok     = (r_ea[RECT_W] == (r_wid != '0)) && !w_wclash;
        o_stat.k_end    = r_k >= r_q;
        o_stat.k_clash  = (r_eb[RECT_W+SURF_W:RECT_W+1] == r_ea[RECT_W+SURF_W:RECT_W+1])
                          && rect_meet(w_b_rect, w_a_rect);
        o_stat.sh_end   = r_k >= r_len;
    end

    assign o_granted     = r_o_granted;
    assign o_granted_tag = r_o_tag;
    assign o_status      = r_o_status;
    assign o_queue_count = r_o_count;
    assign o_busy_mask   = r_o_busy;

endmodule

>>> design/dtrhs_ctrl.sv
// ----------------------------------------------------------------------------
// dtrhs_ctrl
// Sequencer for enqueue, dispatch scan, queue compaction, worker finish and result handoff.
// ----------------------------------------------------------------------------
module dtrhs_ctrl
    import dtrhs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_START,
        S_DIV_WAIT,
        S_ENQ,
        S_SCAN_Q,
        S_SCAN_QCHK,
        S_SCAN_K,
        S_SCAN_KCHK,
        S_GRANT,
        S_SH_CHK,
        S_SH_WR,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_ENQ: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                            n_state          = S_FINISH;
                        end else begin
                            n_state = S_DIV_START;
                        end
                    end
                    CMD_DISPATCH: begin
                        if (i_stat.wid_bad) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BUSY;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN_Q;
                        end
                    end
                    CMD_FINISH: begin
                        o_cmd.finish_worker = 1'b1;
                        n_state             = S_FINISH;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.div_last ? S_ENQ : S_DIV_START;
                end
            end
            S_ENQ: begin
                o_cmd.enq_write = 1'b1;
                n_state         = S_FINISH;
            end
            S_SCAN_Q: begin
                if (i_stat.q_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NONE;
                    n_state          = S_FINISH;
                end else begin
                    n_state = S_SCAN_QCHK;
                end
            end
            S_SCAN_QCHK: begin
                if (i_stat.q_ok) begin
                    n_state = S_SCAN_K;
                end else begin
                    o_cmd.q_next = 1'b1;
                    n_state      = S_SCAN_Q;
                end
            end
            S_SCAN_K: begin
                n_state = i_stat.k_end ? S_GRANT : S_SCAN_KCHK;
            end
            S_SCAN_KCHK: begin
                if (i_stat.k_clash) begin
                    o_cmd.q_next = 1'b1;
                    n_state      = S_SCAN_Q;
                end else begin
                    o_cmd.k_next = 1'b1;
                    n_state      = S_SCAN_K;
                end
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state     = S_SH_CHK;
            end
            S_SH_CHK: begin
                if (i_stat.sh_end) begin
                    o_cmd.sh_done = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.sh_write = 1'b1;
                n_state        = S_SH_CHK;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

>>> design/draw_task_region_hazard_scheduler_top.sv
// ----------------------------------------------------------------------------
// draw_task_region_hazard_scheduler_top
// Draw task queue with region hazard checks against busy workers.
// ----------------------------------------------------------------------------
// One word in, one word out. Items are handled one at a time. A finish, no-op
// or rejected command goes from decode straight to its result. An enqueue
// maps the four clip corners onto the grid with one shared bit-serial
// divider, one corner after the other. A dispatch scans the queue memory
// entry by entry, each candidate checked against all busy workers at once and
// then against every earlier entry in turn; after a grant each later entry is
// moved down by one to close the gap left by the granted task. A result that
// is not taken holds the next one back in its last state. A new word is taken
// while the previous result still waits.
module draw_task_region_hazard_scheduler_top
    import dtrhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int WORKERS     = WORKERS_DEF,
    parameter int GRID_COLS   = GRID_COLS_DEF,
    parameter int GRID_ROWS   = GRID_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [WID_W-1:0]    i_worker_id,
    input  logic [TAG_W-1:0]    i_task_tag,
    input  logic [SURF_W-1:0]   i_surface_id,
    input  logic                i_hw_capable,
    input  logic [COORD_W-1:0]  i_rect_x1,
    input  logic [COORD_W-1:0]  i_rect_y1,
    input  logic [COORD_W-1:0]  i_rect_x2,
    input  logic [COORD_W-1:0]  i_rect_y2,
    input  logic [SIZE_W-1:0]   i_surface_width,
    input  logic [SIZE_W-1:0]   i_surface_height,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_granted,
    output logic [TAG_W-1:0]    o_granted_tag,
    output logic [STATUS_W-1:0] o_status,
    output logic [QCNT_W-1:0]   o_queue_count,
    output logic [BUSY_W-1:0]   o_busy_mask
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    dtrhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    dtrhs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORKERS     (WORKERS),
        .GRID_COLS   (GRID_COLS),
        .GRID_ROWS   (GRID_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_cmd      (i_cmd),
        .i_in_wid      (i_worker_id),
        .i_in_tag      (i_task_tag),
        .i_in_surf     (i_surface_id),
        .i_in_hw       (i_hw_capable),
        .i_in_x1       (i_rect_x1),
        .i_in_y1       (i_rect_y1),
        .i_in_x2       (i_rect_x2),
        .i_in_y2       (i_rect_y2),
        .i_in_w        (i_surface_width),
        .i_in_h        (i_surface_height),
        .o_granted     (o_granted),
        .o_granted_tag (o_granted_tag),
        .o_status      (o_status),
        .o_queue_count (o_queue_count),
        .o_busy_mask   (o_busy_mask)
    );

endmodule

>>> design/dtrhs_chk.sv
// ----------------------------------------------------------------------------
// dtrhs_chk
// Port-level checks on the result word of the draw task scheduler.
// ----------------------------------------------------------------------------
module dtrhs_chk
    import dtrhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_granted,
    input logic [TAG_W-1:0]    o_granted_tag,
    input logic [STATUS_W-1:0] o_status,
    input logic [QCNT_W-1:0]   o_queue_count,
    input logic [BUSY_W-1:0]   o_busy_mask
);

    // a waiting word is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_granted_tag))
        else $error("result word dropped or changed while stalled");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> o_status == ST_OK && o_busy_mask != '0)
        else $error("grant without ok status or busy worker");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_granted |-> o_granted_tag == '0)
        else $error("tag shown without grant");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FULL |-> o_queue_count == QCNT_W'(QUEUE_DEPTH))
        else $error("queue full reported with room left");

endmodule

bind draw_task_region_hazard_scheduler_top dtrhs_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dtrhs_chk (.*);
